// ----- hw/rtl/glmp_pkg.sv -----
package glmp_pkg;

	localparam int LINE_CAPACITY = 64;
	localparam int COUNT_BITS    = 16;
	localparam int CNT_W         = $clog2(LINE_CAPACITY);
	localparam int NUM_CLASSES   = 5;
	localparam int CLASS_W       = 3;

	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0] CHAR_SPACE   = 8'h20;
	localparam logic [7:0] CHAR_T       = 8'h54;
	localparam logic [7:0] CHAR_B       = 8'h42;
	localparam logic [7:0] CHAR_R       = 8'h52;
	localparam logic [7:0] CHAR_A       = 8'h41;
	localparam logic [7:0] CHAR_E       = 8'h45;

	localparam logic [2:0] CODE_SAT = 3'd5;

	localparam logic [2:0] DIR_FROM_THERM = 3'd0;
	localparam logic [2:0] DIR_FROM_BOIL  = 3'd1;
	localparam logic [2:0] DIR_TO_BOIL    = 3'd2;
	localparam logic [2:0] DIR_TO_THERM   = 3'd3;
	localparam logic [2:0] DIR_ERROR      = 3'd4;
	localparam logic [2:0] DIR_UNEXPECTED = 3'd5;

	// One finished line as the front hands it to the back.
	typedef struct packed {
		logic             expired;
		logic [CNT_W-1:0] length;
		logic [7:0]       lead;
		logic [31:0]      hex;
		logic             hex_ok;
		logic             err_match;
		logic [2:0]       code;
		logic             code_seen;
	} line_rec_t;

	typedef struct packed {
		logic      valid;
		line_rec_t rec;
	} push_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	typedef struct packed {
		logic [2:0]  direction;
		logic [2:0]  message_type;
		logic [7:0]  data_id;
		logic [15:0] data_value;
		logic [2:0]  error_class;
		logic        counted;
		logic [15:0] error_count;
		logic [5:0]  line_length;
	} result_t;

	// Bit 4 flags a hex digit, bits 3..0 hold its value.
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
		else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
		else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
		return r;
	endfunction

	function automatic logic [7:0] err_char(input logic [2:0] pos);
		logic [7:0] r;
		case (pos)
			3'd0: r = 8'h45;
			3'd1: r = 8'h72;
			3'd2: r = 8'h72;
			3'd3: r = 8'h6F;
			3'd4: r = 8'h72;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

// ----- hw/rtl/glmp_in_if.sv -----
interface glmp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       wait_expired;

	modport source (output valid, output rx_byte, output wait_expired, input ready);
	modport sink (input valid, input rx_byte, input wait_expired, output ready);
endinterface

// ----- hw/rtl/glmp_out_if.sv -----
interface glmp_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  direction;
	logic [2:0]  message_type;
	logic [7:0]  data_id;
	logic [15:0] data_value;
	logic [2:0]  error_class;
	logic        counted;
	logic [15:0] error_count;
	logic [5:0]  line_length;

	modport source (output valid, output direction, output message_type, output data_id,
		output data_value, output error_class, output counted, output error_count,
		output line_length, input ready);
	modport sink (input valid, input direction, input message_type, input data_id,
		input data_value, input error_class, input counted, input error_count,
		input line_length, output ready);
endinterface

// ----- hw/rtl/glmp_front.sv -----
module glmp_front
	import glmp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	glmp_in_if.sink      rx,
	input  queue_stat_t  qstat,
	output push_t        push
);

	logic [CNT_W-1:0] cnt_q;
	logic [7:0]       lead_q;
	logic [31:0]      hex_q;
	logic             hex_ok_q;
	logic             match_q;
	logic [2:0]       code_q;
	logic             seen_q;
	logic             closed_q;

	logic [CNT_W-1:0] cnt_n;
	logic [7:0]       lead_n;
	logic [31:0]      hex_n;
	logic             hex_ok_n;
	logic             match_n;
	logic [2:0]       code_n;
	logic             seen_n;
	logic             closed_n;

	logic [4:0] hd;
	logic       accept;
	logic       is_nl;
	logic       keep;
	logic       at_cap;
	logic       line_end;

	assign rx.ready = !qstat.full;
	assign accept   = rx.valid && rx.ready;
	assign hd       = hex_val(rx.rx_byte);
	assign is_nl    = rx.rx_byte == CHAR_NEWLINE;
	assign keep     = !rx.wait_expired && rx.rx_byte >= CHAR_SPACE;
	assign at_cap   = cnt_q == CNT_W'(LINE_CAPACITY - 2);

	always_comb begin
		lead_n   = lead_q;
		hex_n    = hex_q;
		hex_ok_n = hex_ok_q;
		match_n  = match_q;
		code_n   = code_q;
		seen_n   = seen_q;
		closed_n = closed_q;
		cnt_n    = cnt_q + CNT_W'(1);
		if (cnt_q == '0) lead_n = rx.rx_byte;
		if (cnt_q < CNT_W'(5) && rx.rx_byte != err_char(3'(cnt_q))) match_n = 1'b0;
		if (cnt_q >= CNT_W'(1) && cnt_q <= CNT_W'(8)) begin
			if (!hd[4]) hex_ok_n = 1'b0;
			else hex_n = {hex_q[27:0], hd[3:0]};
		end
		// The code value saturates at five, which already means an unknown class.
		if (cnt_q >= CNT_W'(6) && !closed_q) begin
			if (!hd[4]) begin
				closed_n = 1'b1;
			end else begin
				code_n = (code_q != 3'd0 || hd[3:0] > 4'd5) ? CODE_SAT : hd[2:0];
				seen_n = 1'b1;
			end
		end
	end

	assign line_end = rx.wait_expired || is_nl || (keep && at_cap);

	always_comb begin
		push.valid = accept && line_end;
		if (!rx.wait_expired && !is_nl) begin
			push.rec = '{expired: 1'b0, length: cnt_n, lead: lead_n, hex: hex_n,
				hex_ok: hex_ok_n, err_match: match_n, code: code_n, code_seen: seen_n};
		end else begin
			push.rec = '{expired: rx.wait_expired, length: cnt_q, lead: lead_q, hex: hex_q,
				hex_ok: hex_ok_q, err_match: match_q, code: code_q, code_seen: seen_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			lead_q   <= '0;
			hex_q    <= '0;
			hex_ok_q <= 1'b1;
			match_q  <= 1'b1;
			code_q   <= '0;
			seen_q   <= 1'b0;
			closed_q <= 1'b0;
		end else if (accept) begin
			if (line_end) begin
				cnt_q    <= '0;
				lead_q   <= '0;
				hex_q    <= '0;
				hex_ok_q <= 1'b1;
				match_q  <= 1'b1;
				code_q   <= '0;
				seen_q   <= 1'b0;
				closed_q <= 1'b0;
			end else if (keep) begin
				cnt_q    <= cnt_n;
				lead_q   <= lead_n;
				hex_q    <= hex_n;
				hex_ok_q <= hex_ok_n;
				match_q  <= match_n;
				code_q   <= code_n;
				seen_q   <= seen_n;
				closed_q <= closed_n;
			end
		end
	end

endmodule

// ----- hw/rtl/glmp_queue.sv -----
module glmp_queue
	import glmp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  push_t       push,
	input  logic        pop,
	output queue_stat_t qstat,
	output line_rec_t   head
);

	line_rec_t  slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] fill_q;

	assign qstat.full  = fill_q == 2'd2;
	assign qstat.empty = fill_q == 2'd0;
	assign head        = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push.valid) slot_q[wr_q] <= push.rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= 1'b0;
			rd_q   <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push.valid) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			fill_q <= fill_q + 2'(push.valid) - 2'(pop);
		end
	end

endmodule

// ----- hw/rtl/glmp_back.sv -----
module glmp_back
	import glmp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  queue_stat_t qstat,
	input  line_rec_t   head,
	output logic        pop,
	glmp_out_if.source  res
);

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	logic [COUNT_BITS-1:0] err_cnt_q [NUM_CLASSES];
	result_t               res_q;
	logic                  res_valid_q;

	logic                  is_err;
	logic [CLASS_W-1:0]    cls;
	logic [COUNT_BITS-1:0] cnt_new;
	logic [31:0]           cnt_ext;
	logic [7:0]            len_ext;
	result_t               res_n;

	assign pop = !qstat.empty && (!res_valid_q || res.ready);

	assign is_err = !head.expired && head.err_match && head.length >= CNT_W'(5);
	assign cls = (head.code_seen && head.code >= 3'd1 && head.code <= 3'd4) ?
		CLASS_W'(head.code) : CLASS_W'(0);
	assign cnt_new = (err_cnt_q[cls] < COUNT_MAX) ? err_cnt_q[cls] + COUNT_BITS'(1)
		: err_cnt_q[cls];
	assign cnt_ext = 32'(cnt_new);
	assign len_ext = 8'(head.length);

	always_comb begin
		res_n = '0;
		res_n.line_length = len_ext[5:0];
		if (head.expired) begin
			res_n.direction = DIR_UNEXPECTED;
		end else if (is_err) begin
			res_n.direction   = DIR_ERROR;
			res_n.error_class = cls;
			res_n.counted     = 1'b1;
			res_n.error_count = cnt_ext[15:0];
		end else if (!head.hex_ok || head.length < CNT_W'(9)) begin
			res_n.direction = DIR_UNEXPECTED;
		end else begin
			res_n.message_type = head.hex[30:28];
			res_n.data_id      = head.hex[23:16];
			res_n.data_value   = head.hex[15:0];
			case (head.lead)
				CHAR_T:  res_n.direction = DIR_FROM_THERM;
				CHAR_B:  res_n.direction = DIR_FROM_BOIL;
				CHAR_R:  res_n.direction = DIR_TO_BOIL;
				CHAR_A:  res_n.direction = DIR_TO_THERM;
				CHAR_E:  res_n.direction = DIR_ERROR;
				default: res_n.direction = DIR_UNEXPECTED;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) res_q <= res_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			for (int i = 0; i < NUM_CLASSES; i++) err_cnt_q[i] <= '0;
		end else begin
			if (pop) res_valid_q <= 1'b1;
			else if (res.ready) res_valid_q <= 1'b0;
			if (pop && is_err) err_cnt_q[cls] <= cnt_new;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.direction    = res_q.direction;
	assign res.message_type = res_q.message_type;
	assign res.data_id      = res_q.data_id;
	assign res.data_value   = res_q.data_value;
	assign res.error_class  = res_q.error_class;
	assign res.counted      = res_q.counted;
	assign res.error_count  = res_q.error_count;
	assign res.line_length  = res_q.line_length;

endmodule

// ----- hw/rtl/gateway_line_message_parser.sv -----
// Gateway line message parser.
// The rx channel carries one received word per handshake: a serial character and a
// wait-expired flag. Characters are gathered into a line; newline, a full line buffer
// or an expired wait ends it, and each finished line gives one word on the res channel
// with its direction, message fields, error counter update and length.
// Throughput: one rx word per cycle. The front updates the line state in the cycle a
// character is taken, so nothing limits the input rate but the two-entry line queue.
// The record of the line is written into the queue when the character that ends it is
// accepted; from there the back moves it into its output register once that is free,
// and for an error line updates one of the five error counters in the same step.
// When res is stalled the output register holds its word, the queue fills with up to
// two finished lines, and only then does rx.ready drop; a line can keep growing while
// the queue has room.
// Reset clears the partial line, the queue's pointers and fill count, the output valid
// flag and all error counters at once; no clearing pass is needed.
module gateway_line_message_parser
	import glmp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	glmp_in_if.sink     rx,
	glmp_out_if.source  res
);

	push_t       push;
	queue_stat_t qstat;
	line_rec_t   head;
	logic        pop;

	glmp_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.qstat  (qstat),
		.push   (push)
	);

	glmp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.qstat  (qstat),
		.head   (head)
	);

	glmp_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.qstat  (qstat),
		.head   (head),
		.pop    (pop),
		.res    (res)
	);

	a_queue_state: assert property (@(posedge clk) disable iff (!arst_n)
		!(qstat.full && qstat.empty))
		else $error("line queue reports full and empty at once");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> !qstat.full)
		else $error("line pushed into a full queue");

	a_expired_ends_line: assert property (@(posedge clk) disable iff (!arst_n)
		(rx.valid && rx.ready && rx.wait_expired) |-> push.valid)
		else $error("expired wait did not end the line");

	a_pop_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("back took a line from an empty queue");

endmodule

// ----- tb/sv/gateway_line_message_parser_tb.sv -----
module gateway_line_message_parser_tb;
	import glmp_pkg::*;

	localparam int unsigned RANDOM_WORDS = 1100;
	localparam int unsigned STALL_LIMIT  = 3000;
	localparam int unsigned HOLD_START   = 600;
	localparam int unsigned HOLD_LEN     = 400;
	localparam int unsigned CALM_FIRST   = 1200;
	localparam int unsigned CALM_LAST    = 1900;
	localparam int unsigned TAIL_CYCLES  = 20;
	localparam logic [39:0] ERROR_TEXT   = "Error";
	localparam longint unsigned TALLY_MAX = (64'd1 << COUNT_BITS) - 1;

	typedef struct {
		logic [7:0] ch;
		logic       expired;
	} rx_word_t;

	logic clk = 1'b0;
	logic arst_n;

	glmp_in_if  rx_ch ();
	glmp_out_if res_ch ();

	gateway_line_message_parser u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.res    (res_ch)
	);

	always #5 clk = ~clk;

	rx_word_t rx_pending[$];
	result_t  expected_lines[$];

	// Line state of the parser as the predictor sees it.
	int unsigned     line_len;
	logic [7:0]      lead_ch;
	logic [31:0]     msg_bits;
	bit              msg_hex_ok;
	bit              err_prefix_ok;
	int unsigned     code_acc;
	bit              code_seen;
	bit              code_done;
	longint unsigned err_tally[NUM_CLASSES];

	int unsigned mismatches = 0;
	int unsigned rx_words = 0;
	int unsigned res_words = 0;
	int unsigned cyc = 0;
	bit          rx_fire = 1'b0;
	bit          calm;
	int unsigned hold_left = 0;
	bit          hold_done = 1'b0;

	assign calm = (cyc >= CALM_FIRST) && (cyc < CALM_LAST);

	function automatic bit hex_digit(input logic [7:0] c, output logic [3:0] v);
		v = 4'd0;
		if (c >= "0" && c <= "9") v = 4'(c - "0");
		else if (c >= "a" && c <= "f") v = 4'(c - "a" + 10);
		else if (c >= "A" && c <= "F") v = 4'(c - "A" + 10);
		else return 1'b0;
		return 1'b1;
	endfunction

	function automatic void clear_line();
		line_len      = 0;
		lead_ch       = 8'h00;
		msg_bits      = 32'h0;
		msg_hex_ok    = 1'b1;
		err_prefix_ok = 1'b1;
		code_acc      = 0;
		code_seen     = 1'b0;
		code_done     = 1'b0;
	endfunction

	function automatic void keep_char(input logic [7:0] c);
		logic [3:0]  v;
		bit          is_hex;
		int unsigned pos;
		int unsigned acc;
		pos = line_len;
		is_hex = hex_digit(c, v);
		if (pos == 0) lead_ch = c;
		if (pos < 5 && c != ERROR_TEXT[8*(4-pos) +: 8]) err_prefix_ok = 1'b0;
		if (pos >= 1 && pos <= 8) begin
			if (!is_hex) msg_hex_ok = 1'b0;
			else msg_bits = {msg_bits[27:0], v};
		end
		// The error code is a run of hex digits from position 6, clamped to the
		// saturation code so the running value never grows past it.
		if (pos >= 6 && !code_done) begin
			if (!is_hex) begin
				code_done = 1'b1;
			end else begin
				acc = code_acc * 16 + v;
				code_acc = (acc > CODE_SAT) ? CODE_SAT : acc;
				code_seen = 1'b1;
			end
		end
		line_len = pos + 1;
	endfunction

	function automatic void close_line();
		result_t     r;
		int unsigned cls;
		r = '0;
		r.line_length = 6'(line_len);
		if (err_prefix_ok && line_len >= 5) begin
			cls = (code_seen && code_acc >= 1 && code_acc <= 4) ? code_acc : 0;
			if (err_tally[cls] < TALLY_MAX) err_tally[cls]++;
			r.direction   = DIR_ERROR;
			r.error_class = 3'(cls);
			r.counted     = 1'b1;
			r.error_count = 16'(err_tally[cls]);
		end else if (!msg_hex_ok || line_len < 9) begin
			r.direction = DIR_UNEXPECTED;
		end else begin
			r.message_type = msg_bits[30:28];
			r.data_id      = msg_bits[23:16];
			r.data_value   = msg_bits[15:0];
			case (lead_ch)
				CHAR_T: r.direction = DIR_FROM_THERM;
				CHAR_B: r.direction = DIR_FROM_BOIL;
				CHAR_R: r.direction = DIR_TO_BOIL;
				CHAR_A: r.direction = DIR_TO_THERM;
				CHAR_E: r.direction = DIR_ERROR;
				default: r.direction = DIR_UNEXPECTED;
			endcase
		end
		expected_lines.push_back(r);
		clear_line();
	endfunction

	function automatic void take_word(input logic [7:0] c, input logic expired);
		result_t r;
		if (expired) begin
			r = '0;
			r.direction   = DIR_UNEXPECTED;
			r.line_length = 6'(line_len);
			expected_lines.push_back(r);
			clear_line();
		end else if (c == CHAR_NEWLINE) begin
			close_line();
		end else if (c >= CHAR_SPACE) begin
			keep_char(c);
			if (line_len >= LINE_CAPACITY - 1) close_line();
		end
	endfunction

	function automatic void push_char(input logic [7:0] c);
		rx_word_t w;
		w.ch = c;
		w.expired = 1'b0;
		rx_pending.push_back(w);
	endfunction

	function automatic void push_expired();
		rx_word_t w;
		w.ch = 8'($urandom_range(255));
		w.expired = 1'b1;
		rx_pending.push_back(w);
	endfunction

	function automatic void push_text(input string s);
		for (int i = 0; i < s.len(); i++) push_char(s[i]);
	endfunction

	function automatic logic [7:0] rand_hex_char();
		int unsigned v;
		v = $urandom_range(15);
		if (v < 10) return 8'("0" + v);
		return 8'(($urandom_range(1) ? "A" : "a") + v - 10);
	endfunction

	function automatic logic [7:0] rand_printable();
		return 8'($urandom_range(8'hFF, 8'h20));
	endfunction

	function automatic void end_line();
		if ($urandom_range(99) < 5) push_expired();
		else push_char(CHAR_NEWLINE);
	endfunction

	function automatic void add_random_line();
		int unsigned kind;
		int unsigned n;
		logic [7:0]  leads[5];
		leads = '{CHAR_T, CHAR_B, CHAR_R, CHAR_A, CHAR_E};
		kind = $urandom_range(99);
		if (kind < 55) begin
			if ($urandom_range(9) == 0) push_char(rand_printable());
			else push_char(leads[$urandom_range(4)]);
			for (int i = 0; i < 8; i++) begin
				if ($urandom_range(99) < 3) push_char(rand_printable());
				else push_char(rand_hex_char());
				if ($urandom_range(99) < 2) push_char(8'($urandom_range(8'h1F)));
			end
			n = $urandom_range(3);
			repeat (n) push_char(rand_printable());
			end_line();
		end else if (kind < 72) begin
			push_text("Error");
			if ($urandom_range(9) != 0) push_char(rand_printable());
			n = $urandom_range(4);
			repeat (n) begin
				if ($urandom_range(99) < 60) push_char(8'("0" + $urandom_range(4)));
				else push_char(rand_hex_char());
			end
			if ($urandom_range(1)) push_char(rand_printable());
			end_line();
		end else if (kind < 85) begin
			n = $urandom_range(12);
			repeat (n) push_char(8'($urandom_range(255)));
			end_line();
		end else if (kind < 95) begin
			n = $urandom_range(12);
			repeat (n) push_char(rand_printable());
			push_expired();
		end else if (kind < 97) begin
			repeat (LINE_CAPACITY - 1) push_char(rand_printable());
		end else if (kind < 99) begin
			push_char(CHAR_NEWLINE);
		end else begin
			push_expired();
		end
	endfunction

	task automatic report(input string msg);
		mismatches++;
		$display("mismatch: %s", msg);
	endtask

	task automatic check_field(input string name, input int unsigned got,
			input int unsigned want);
		if (got != want)
			report($sformatf("line %0d %s got %0d want %0d", res_words, name, got, want));
	endtask

	// Input side: feed accepted words into the predictor.
	always @(posedge clk) begin
		cyc <= cyc + 1;
		rx_fire = arst_n && rx_ch.valid && rx_ch.ready;
		if (rx_fire) begin
			take_word(rx_ch.rx_byte, rx_ch.wait_expired);
			rx_words++;
		end
	end

	// Output side: compare each result word with the oldest predicted line.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			res_words++;
			if (expected_lines.size() == 0) begin
				report($sformatf("result word %0d with no line pending", res_words));
			end else begin
				want = expected_lines.pop_front();
				check_field("direction", res_ch.direction, want.direction);
				check_field("message_type", res_ch.message_type, want.message_type);
				check_field("data_id", res_ch.data_id, want.data_id);
				check_field("data_value", res_ch.data_value, want.data_value);
				check_field("error_class", res_ch.error_class, want.error_class);
				check_field("counted", res_ch.counted, want.counted);
				check_field("error_count", res_ch.error_count, want.error_count);
				check_field("line_length", res_ch.line_length, want.line_length);
			end
		end
	end

	always @(negedge clk) begin
		rx_word_t w;
		if (arst_n && (!rx_ch.valid || rx_fire)) begin
			if (rx_pending.size() > 0 && (calm || $urandom_range(99) >= 30)) begin
				w = rx_pending.pop_front();
				rx_ch.rx_byte      <= w.ch;
				rx_ch.wait_expired <= w.expired;
				rx_ch.valid        <= 1'b1;
			end else begin
				rx_ch.valid <= 1'b0;
			end
		end
	end

	// Receiver, with one long hold-off so the line queue fills and rx stalls.
	always @(negedge clk) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (!hold_done && cyc >= HOLD_START) begin
				hold_left = HOLD_LEN;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= calm || ($urandom_range(99) >= 30);
			end
		end
	end

	initial begin
		int unsigned stall;
		int unsigned last_rx;
		int unsigned last_res;
		int unsigned target;
		bit          timed_out;
		rx_ch.valid        = 1'b0;
		rx_ch.rx_byte      = 8'h00;
		rx_ch.wait_expired = 1'b0;
		res_ch.ready       = 1'b0;
		arst_n             = 1'b0;
		clear_line();
		foreach (err_tally[i]) err_tally[i] = 0;

		push_text("T1A2B3C4D\n");
		push_text("B70FFFFFF\n");
		push_text("R00000000\n");
		push_text("Aabcdef01\n");
		push_text("EF0123456 tail\n");
		push_text("Z12345678\n");
		push_text("T1234567\n");
		push_text("T12G45678\n");
		push_text("\n");
		push_text("Error 01\n");
		push_text("Error:2\n");
		push_text("Error 3abc\n");
		push_text("Error 4 x\n");
		push_text("Error 00\n");
		push_text("Error\n");
		push_text("Erro\n");
		push_text("Error ZZ\n");
		// Control characters in the middle of a line are dropped.
		push_text("B4");
		push_char(8'h01);
		push_char(8'h1F);
		push_char(8'h0D);
		push_text("0123456\n");
		// High bytes are kept and break the hex field.
		push_char(CHAR_T);
		push_char(8'h80);
		push_char(8'hFF);
		push_text("1234567\n");
		push_text("R1234");
		push_expired();
		push_expired();
		// A full line ends on its own without a newline.
		push_char(CHAR_A);
		repeat (LINE_CAPACITY - 2) push_char(rand_hex_char());
		push_char(8'h7F);
		repeat (LINE_CAPACITY - 2) push_char(8'h7F);

		target = rx_pending.size() + RANDOM_WORDS;
		while (rx_pending.size() < target) add_random_line();
		push_char(CHAR_NEWLINE);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		stall = 0;
		last_rx = 0;
		last_res = 0;
		timed_out = 1'b0;
		while (rx_pending.size() > 0 || rx_ch.valid || expected_lines.size() > 0) begin
			@(negedge clk);
			if (rx_words != last_rx || res_words != last_res) stall = 0;
			else stall++;
			last_rx = rx_words;
			last_res = res_words;
			if (stall >= STALL_LIMIT) begin
				timed_out = 1'b1;
				break;
			end
		end

		if (timed_out) begin
			$display("[FAIL] regression broken");
		end else begin
			repeat (TAIL_CYCLES) @(posedge clk);
			if (mismatches == 0 && expected_lines.size() == 0) begin
				$display("[ OK ] regression clean");
			end else begin
				$display("[FAIL] regression broken");
			end
		end
		$finish;
	end

endmodule
